>>> rtl/core/tqc_pkg.sv
// Package for the time-tagged command queue: field widths, entry layout,
// command and status codes. No dependencies.
package tqc_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_W = 32;
	localparam int CODE_W = 8;

	localparam logic CMD_SCHEDULE = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2,
		ST_NOT_DUE = 2'd3
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] tag;
		logic [CODE_W-1:0] code;
	} entry_t;

endpackage

>>> rtl/core/tqc_cmd_if.sv
// Command channel of the time-tagged command queue: valid, ready and payload.
// Depends on tqc_pkg for field widths.
interface tqc_cmd_if;
	logic valid;
	logic ready;
	logic command;
	logic [tqc_pkg::TIME_W-1:0] time_value;
	logic [tqc_pkg::CODE_W-1:0] request_in;

	modport source(output valid, command, time_value, request_in, input ready);
	modport sink(input valid, command, time_value, request_in, output ready);
endinterface

>>> rtl/core/tqc_res_if.sv
// Result channel of the time-tagged command queue: valid, ready and payload.
// Depends on tqc_pkg for field widths and the status codes.
interface tqc_res_if;
	logic valid;
	logic ready;
	logic due_valid;
	logic [tqc_pkg::CODE_W-1:0] request_out;
	tqc_pkg::status_t status;

	modport source(output valid, due_valid, request_out, status, input ready);
	modport sink(input valid, due_valid, request_out, status, output ready);
endinterface

>>> rtl/core/tqc_store.sv
// Entry store of the time-tagged command queue: one write port and one read
// port with registered read data. Depends on tqc_pkg for the entry layout.
module tqc_store #(
	parameter int QUEUE_DEPTH = tqc_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic we,
	input logic [$clog2(QUEUE_DEPTH)-1:0] waddr,
	input tqc_pkg::entry_t wdata,
	input logic [$clog2(QUEUE_DEPTH)-1:0] raddr,
	output tqc_pkg::entry_t rdata
);

	tqc_pkg::entry_t mem [QUEUE_DEPTH];
	tqc_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/time_tagged_command_queue_core.sv
// Top level of the time-tagged command queue: a sorted store walked by one
// comparator under a small sequencer. Depends on tqc_pkg, tqc_cmd_if,
// tqc_res_if and tqc_store.
//
//   port   direction  words carried
//   cmd    in         command, time_value, request_in
//   rsp    out        due_valid, request_out, status
//
// After a command is taken, cmd.ready stays low while the block works: on a
// schedule, until each queued entry with a later tag has moved up one place;
// on a check that finds nothing due, through a compare of the head entry; on
// a pop, until the entries behind it have shifted down; on a full queue or an
// empty check, only through the result state. The store's single read port
// and the comparator walk one entry a cycle. Reset empties the queue at once.
// A waiting result does not block the next command; only the hand-over of the
// following result waits for rsp.ready, and the block stays busy until it does.
module time_tagged_command_queue_core #(
	parameter int QUEUE_DEPTH = tqc_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	tqc_cmd_if.sink cmd,
	tqc_res_if.source rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCMP = 5'b00010,
		S_CCMP = 5'b00100,
		S_CSH = 5'b01000,
		S_FIN = 5'b10000
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [tqc_pkg::TIME_W-1:0] tag_q;
	logic [tqc_pkg::CODE_W-1:0] code_q;
	logic res_due_q;
	logic [tqc_pkg::CODE_W-1:0] res_code_q;
	tqc_pkg::status_t res_status_q;
	logic out_valid_q;
	logic out_due_q;
	logic [tqc_pkg::CODE_W-1:0] out_code_q;
	tqc_pkg::status_t out_status_q;

	logic accept;
	logic is_full;
	logic is_empty;
	logic later;
	logic shift_up;
	logic sh_last;
	logic out_free;
	logic we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	tqc_pkg::entry_t wdata;
	tqc_pkg::entry_t rd_data;

	tqc_store #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	assign accept = cmd.valid && cmd.ready;
	assign is_full = (count_q == CW'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	// The one shared comparator: stored tag against the held tag or time.
	assign later = (rd_data.tag > tag_q);
	assign shift_up = (idx_q != '0) && later;
	assign sh_last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = rd_data;
		raddr = '0;
		case (state_q)
			S_IDLE: begin
				raddr = (cmd.command == tqc_pkg::CMD_CHECK) ? '0 : AW'(count_q - CW'(1));
			end
			S_SCMP: begin
				we = 1'b1;
				waddr = idx_q;
				wdata = shift_up ? rd_data : {tag_q, code_q};
				raddr = idx_q - AW'(2);
			end
			S_CCMP: begin
				raddr = AW'(1);
			end
			S_CSH: begin
				we = 1'b1;
				waddr = idx_q - AW'(1);
				wdata = rd_data;
				raddr = idx_q + AW'(1);
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.command == tqc_pkg::CMD_SCHEDULE) begin
							state_q <= is_full ? S_FIN : S_SCMP;
						end else begin
							state_q <= is_empty ? S_FIN : S_CCMP;
						end
					end
				end
				S_SCMP: begin
					if (!shift_up) begin
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_CCMP: begin
					if (later) begin
						state_q <= S_FIN;
					end else if (count_q == CW'(1)) begin
						count_q <= count_q - CW'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_CSH;
					end
				end
				S_CSH: begin
					if (sh_last) begin
						count_q <= count_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					tag_q <= cmd.time_value;
					code_q <= cmd.request_in;
					idx_q <= AW'(count_q);
					res_due_q <= 1'b0;
					res_code_q <= '0;
					if (cmd.command == tqc_pkg::CMD_SCHEDULE) begin
						res_status_q <= is_full ? tqc_pkg::ST_FULL : tqc_pkg::ST_OK;
					end else begin
						res_status_q <= is_empty ? tqc_pkg::ST_EMPTY : tqc_pkg::ST_OK;
					end
				end
			end
			S_SCMP: begin
				if (shift_up) begin
					idx_q <= idx_q - AW'(1);
				end
			end
			S_CCMP: begin
				idx_q <= AW'(1);
				if (later) begin
					res_status_q <= tqc_pkg::ST_NOT_DUE;
				end else begin
					res_due_q <= 1'b1;
					res_code_q <= rd_data.code;
					res_status_q <= tqc_pkg::ST_OK;
				end
			end
			S_CSH: begin
				idx_q <= idx_q + AW'(1);
			end
			S_FIN: begin
				if (out_free) begin
					out_due_q <= res_due_q;
					out_code_q <= res_code_q;
					out_status_q <= res_status_q;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.due_valid = out_due_q;
	assign rsp.request_out = out_code_q;
	assign rsp.status = out_status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("Entry count exceeds the queue depth.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd.ready)
		else $error("Command channel ready right after a command was taken.");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == S_SCMP ||
		$past(state_q) == S_CCMP || $past(state_q) == S_CSH))
		else $error("Entry count changed outside a queue update.");

	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.due_valid) |-> (rsp.status == tqc_pkg::ST_OK))
		else $error("Popped entry reported with a failure status.");
`endif

endmodule
